// ----- hdl/blr_pkg.sv -----
// Package for the byte lane realigner: widths, register indexes, shared types
// and the byte-lane swap helpers. No dependencies.
package blr_pkg;

    localparam int WORD_BYTES  = 8;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = WORD_BYTES * BYTE_W;
    localparam int OFF_W       = $clog2(WORD_BYTES);
    // The realign buffer holds up to one word less a byte of leftovers plus one new word.
    localparam int BUF_BYTES   = 2 * WORD_BYTES - 1;
    localparam int BUF_W       = BUF_BYTES * BYTE_W;
    localparam int CNT_W       = $clog2(BUF_BYTES + 1);
    localparam int LEN_W       = 16;
    localparam int IDX_W       = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = LEN_W;
    // Queue depth must be a power of two so that the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_OFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_OFF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 2'd3;

    typedef struct packed {
        logic [OFF_W-1:0] src_off;
        logic [OFF_W-1:0] dst_off;
        logic [LEN_W-1:0] len;
        logic             big_endian;
    } t_cfg;

    // One source word after the front end: bytes in address order, starting at
    // the first byte that belongs to the copy.
    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [CNT_W-1:0]  cnt;
        logic              start;
    } t_pkt;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int j = 0; j < WORD_BYTES; j++) begin
            r[j*BYTE_W +: BYTE_W] = w[(WORD_BYTES-1-j)*BYTE_W +: BYTE_W];
        end
        return r;
    endfunction

    function automatic logic [WORD_BYTES-1:0] swap_lanes(input logic [WORD_BYTES-1:0] e);
        logic [WORD_BYTES-1:0] r;
        r = '0;
        for (int j = 0; j < WORD_BYTES; j++) begin
            r[j] = e[WORD_BYTES-1-j];
        end
        return r;
    endfunction

endpackage

// ----- hdl/blr_src_if.sv -----
// Source word channel of the byte lane realigner.
// Depends on blr_pkg.
interface blr_src_if import blr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] source_word;
    logic              start_req;

    modport source (output valid, output source_word, output start_req, input ready);
    modport sink   (input valid, input source_word, input start_req, output ready);
endinterface

// ----- hdl/blr_dst_if.sv -----
// Destination write channel of the byte lane realigner.
// Depends on blr_pkg.
interface blr_dst_if import blr_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [WORD_W-1:0]     dest_word;
    logic [WORD_BYTES-1:0] byte_enable;
    logic [IDX_W-1:0]      dest_index;
    logic                  last;

    modport source (output valid, output dest_word, output byte_enable,
                    output dest_index, output last, input ready);
    modport sink   (input valid, input dest_word, input byte_enable,
                    input dest_index, input last, output ready);
endinterface

// ----- hdl/blr_front.sv -----
// Front end: takes source words, puts their bytes into address order and drops
// the lanes ahead of the source offset on the first word. Depends on blr_pkg, blr_src_if.
module blr_front import blr_pkg::*; (
    blr_src_if.sink i_src,
    input  t_cfg    i_cfg,
    output logic    o_pkt_valid,
    output t_pkt    o_pkt,
    input  logic    i_pkt_ready
);

    logic [OFF_W-1:0]  off;
    logic [WORD_W-1:0] addr_word;

    always_comb begin
        off       = i_src.start_req ? i_cfg.src_off : '0;
        addr_word = i_cfg.big_endian ? swap_bytes(i_src.source_word) : i_src.source_word;
        o_pkt.bytes = addr_word >> (off * BYTE_W);
        o_pkt.cnt   = CNT_W'(WORD_BYTES) - CNT_W'(off);
        o_pkt.start = i_src.start_req;
    end

    assign o_pkt_valid = i_src.valid;
    assign i_src.ready = i_pkt_ready;

endmodule

// ----- hdl/blr_queue.sv -----
// Short queue of front-end packets between the front and back ends.
// Depends on blr_pkg.
module blr_queue import blr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_data,
    output logic o_ready,
    output logic o_valid,
    output t_pkt o_data,
    input  logic i_pop
);

    t_pkt              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/blr_back.sv -----
// Back end: funnel-shift buffer that merges leftover bytes with the next packet
// and writes up to two destination words per packet. Depends on blr_pkg, blr_dst_if.
module blr_back import blr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_pkt_valid,
    input  t_pkt        i_pkt,
    output logic        o_pop,
    blr_dst_if.source   o_dst
);

    logic [BUF_W-1:0]      r_buf;
    logic [CNT_W-1:0]      r_cnt;
    logic [LEN_W-1:0]      r_left;
    logic [IDX_W-1:0]      r_wcnt;
    logic                  r_first;
    logic                  r_busy;
    logic                  r_emits;
    logic                  r_oval;
    logic [WORD_W-1:0]     r_oword;
    logic [WORD_BYTES-1:0] r_oen;
    logic [IDX_W-1:0]      r_oidx;
    logic                  r_olast;

    logic [BUF_W-1:0]      n_buf;
    logic [CNT_W-1:0]      n_cnt;
    logic [LEN_W-1:0]      n_left;
    logic [IDX_W-1:0]      n_wcnt;
    logic                  n_first;
    logic                  n_busy;
    logic                  n_emits;
    logic [WORD_W-1:0]     n_oword;
    logic [WORD_BYTES-1:0] n_oen;
    logic                  n_olast;

    logic                  out_free;
    logic                  emit;
    logic                  can2;
    logic                  item_done;
    logic                  absorb;
    logic [OFF_W-1:0]      pos;
    logic [CNT_W-1:0]      space;
    logic [CNT_W-1:0]      take;
    logic [CNT_W-1:0]      cnt_after;
    logic [LEN_W-1:0]      left_after;
    logic [WORD_W-1:0]     addr_word;
    logic [WORD_BYTES-1:0] addr_en;

    logic [BUF_W-1:0]      buf_l;
    logic [CNT_W-1:0]      cnt_l;
    logic [LEN_W-1:0]      left_l;
    logic [IDX_W-1:0]      wcnt_l;
    logic                  first_l;

    logic [CNT_W-1:0]      base_cnt;
    logic [LEN_W-1:0]      base_left;
    logic [IDX_W-1:0]      base_wcnt;
    logic                  base_first;
    logic [LEN_W-1:0]      need;
    logic [CNT_W-1:0]      add;
    logic [CNT_W-1:0]      m_cnt;
    logic [CNT_W-1:0]      m_space;
    logic [BUF_W-1:0]      shifted;
    logic [BUF_W-1:0]      m_buf;
    logic                  m_can;

    // Emission of one destination word from the buffer.
    always_comb begin
        out_free   = !r_oval || o_dst.ready;
        emit       = r_busy && out_free;
        pos        = r_first ? i_cfg.dst_off : '0;
        space      = CNT_W'(WORD_BYTES) - CNT_W'(pos);
        take       = (r_cnt >= space) ? space : r_cnt;
        cnt_after  = r_cnt - take;
        left_after = r_left - LEN_W'(take);
        // After the first word the offset no longer applies, so a full word is needed
        // unless the rest of the copy fits.
        can2 = (left_after != '0) &&
               ((cnt_after >= CNT_W'(WORD_BYTES)) || (LEN_W'(cnt_after) >= left_after));
        item_done = emit && (r_emits || !can2);
        absorb    = !r_busy || item_done;
        o_pop     = absorb && i_pkt_valid;

        addr_word = r_buf[WORD_W-1:0] << (pos * BYTE_W);
        for (int a = 0; a < WORD_BYTES; a++) begin
            addr_en[a] = (CNT_W'(a) >= CNT_W'(pos)) && (CNT_W'(a) < CNT_W'(pos) + take);
            if (!addr_en[a]) begin
                addr_word[a*BYTE_W +: BYTE_W] = '0;
            end
        end
        n_oword = i_cfg.big_endian ? swap_bytes(addr_word) : addr_word;
        n_oen   = i_cfg.big_endian ? swap_lanes(addr_en) : addr_en;
        n_olast = (left_after == '0);
    end

    // Leftover state once this cycle's word, if any, has gone out.
    always_comb begin
        if (emit) begin
            buf_l   = r_buf >> (take * BYTE_W);
            cnt_l   = cnt_after;
            left_l  = left_after;
            wcnt_l  = r_wcnt + IDX_W'(1);
            first_l = 1'b0;
        end else begin
            buf_l   = r_buf;
            cnt_l   = r_cnt;
            left_l  = r_left;
            wcnt_l  = r_wcnt;
            first_l = r_first;
        end
    end

    // Merge the next packet behind the leftover bytes.
    always_comb begin
        if (i_pkt.start) begin
            base_cnt   = '0;
            base_left  = i_cfg.len;
            base_wcnt  = '0;
            base_first = 1'b1;
        end else begin
            base_cnt   = cnt_l;
            base_left  = left_l;
            base_wcnt  = wcnt_l;
            base_first = first_l;
        end
        need    = base_left - LEN_W'(base_cnt);
        add     = (LEN_W'(i_pkt.cnt) <= need) ? i_pkt.cnt : need[CNT_W-1:0];
        m_cnt   = base_cnt + add;
        shifted = BUF_W'(i_pkt.bytes) << (base_cnt * BYTE_W);
        for (int i = 0; i < BUF_BYTES; i++) begin
            m_buf[i*BYTE_W +: BYTE_W] = (CNT_W'(i) < base_cnt) ? buf_l[i*BYTE_W +: BYTE_W]
                                                               : shifted[i*BYTE_W +: BYTE_W];
        end
        m_space = base_first ? CNT_W'(WORD_BYTES) - CNT_W'(i_cfg.dst_off)
                             : CNT_W'(WORD_BYTES);
        m_can   = (base_left != '0) &&
                  ((m_cnt >= m_space) || (LEN_W'(m_cnt) >= base_left));
    end

    always_comb begin
        if (o_pop) begin
            n_buf   = m_buf;
            n_cnt   = m_cnt;
            n_left  = base_left;
            n_wcnt  = base_wcnt;
            n_first = base_first;
            n_busy  = m_can;
            n_emits = 1'b0;
        end else begin
            n_buf   = buf_l;
            n_cnt   = cnt_l;
            n_left  = left_l;
            n_wcnt  = wcnt_l;
            n_first = first_l;
            n_busy  = emit ? !item_done : r_busy;
            n_emits = emit ? !item_done : r_emits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (emit) begin
            r_oword <= n_oword;
            r_oen   <= n_oen;
            r_oidx  <= r_wcnt;
            r_olast <= n_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_left  <= '0;
            r_wcnt  <= '0;
            r_first <= 1'b0;
            r_busy  <= 1'b0;
            r_emits <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_wcnt  <= n_wcnt;
            r_first <= n_first;
            r_busy  <= n_busy;
            r_emits <= n_emits;
            if (emit) begin
                r_oval <= 1'b1;
            end else if (o_dst.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_dst.valid       = r_oval;
    assign o_dst.dest_word   = r_oword;
    assign o_dst.byte_enable = r_oen;
    assign o_dst.dest_index  = r_oidx;
    assign o_dst.last        = r_olast;

`ifndef SYNTHESIS
    a_held_below_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt < CNT_W'(WORD_BYTES)))
        else $error("leftover bytes fill a whole word while the back end is idle");

    a_held_within_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_cnt) <= r_left)
        else $error("more bytes buffered than remain in the copy");

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("back end busy with nothing left to write");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_olast) |-> item_done)
        else $error("final write did not finish the packet");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !out_free) |=> ($stable(r_cnt) && $stable(r_left) && $stable(r_wcnt)))
        else $error("buffer state moved while the output was stalled");
`endif

endmodule

// ----- hdl/byte_lane_realigner_unit.sv -----
// Channel   Dir  Handshake      Payload
// i_src     in   valid/ready    source_word[63:0], start_req
// o_dst     out  valid/ready    dest_word[63:0], byte_enable[7:0], dest_index[13:0], last
// i_cfg_*   in   write enable   i_cfg_idx selects register, i_cfg_data carries value
//
// A source word is taken every cycle while the two-entry queue has room; a word that
// yields two destination writes holds the funnel-shift buffer until both are out, since
// the output register takes one write per cycle while the destination accepts. A word
// is registered in the queue, then in the buffer, then in the output register. Reset
// is synchronous and clears the configuration, the queue and the buffer control state.
// Either side may stall; the queue lets the front take words while the output is held.
//
// Top level of the byte lane realigner: configuration registers and the front end,
// queue and back end. Depends on blr_pkg, blr_src_if, blr_dst_if and the blr_ modules.
module byte_lane_realigner_unit import blr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    blr_src_if.sink               i_src,
    blr_dst_if.source             o_dst
);

    t_cfg r_cfg;
    logic front_valid;
    t_pkt front_pkt;
    logic q_ready;
    logic q_valid;
    t_pkt q_pkt;
    logic back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_OFF:    r_cfg.src_off    <= i_cfg_data[OFF_W-1:0];
                CFG_DST_OFF:    r_cfg.dst_off    <= i_cfg_data[OFF_W-1:0];
                CFG_LENGTH:     r_cfg.len        <= i_cfg_data[LEN_W-1:0];
                CFG_BIG_ENDIAN: r_cfg.big_endian <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    blr_front u_front (
        .i_src       (i_src),
        .i_cfg       (r_cfg),
        .o_pkt_valid (front_valid),
        .o_pkt       (front_pkt),
        .i_pkt_ready (q_ready)
    );

    blr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_pkt),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_pkt),
        .i_pop   (back_pop)
    );

    blr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pkt_valid (q_valid),
        .i_pkt       (q_pkt),
        .o_pop       (back_pop),
        .o_dst       (o_dst)
    );

endmodule
